/* hdl/vptb_pkg.sv */
// ----------------------------------------------------------------------------
// Virtual periodic timer bank package
// Shared widths, operation and status codes, controller states, the command
// and status bundles between controller and datapath, and a helper function.
// ----------------------------------------------------------------------------
package vptb_pkg;

    localparam int DEF_SLOTS       = 8;
    localparam int DEF_MAX_SYS_POW = 13;

    localparam int OP_W           = 3;
    localparam int SLOT_FIELD_W   = 3;
    localparam int RATE_W         = 32;
    localparam int STAT_W         = 2;
    localparam int POW_W          = 4;
    localparam int MASK_W         = 8;
    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int RATE_CODE_BASE = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_POW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POW     = 1'b1;

    localparam logic [CFG_W-1:0] DEFAULT_POW_RST = 4'd1;
    localparam logic [CFG_W-1:0] MAX_POW_RST     = 4'd10;
    localparam logic [POW_W-1:0] SHARED_POW_RST  = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN     = 3'd0,
        OP_CLOSE    = 3'd1,
        OP_SET_RATE = 3'd2,
        OP_TICK     = 3'd3,
        OP_POLL     = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_RATE = 2'd1,
        STAT_NO_SLOT  = 2'd2,
        STAT_NOT_OPEN = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_OPEN_WR,
        S_CHECK,
        S_MAX_SCAN,
        S_TAKE,
        S_RECOMP,
        S_TICK_SCAN,
        S_POLL_RD,
        S_POLL_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SCAN_MAX,
        SCAN_RECOMP,
        SCAN_TICK
    } scan_kind_t;

    typedef struct packed {
        logic       load_item;
        logic       set_status;
        stat_t      status_code;
        logic       find_step;
        logic       scan_clr;
        logic       scan_run;
        scan_kind_t scan_kind;
        logic       apply;
        logic       open_write;
        logic       close_write;
        logic       take_best;
        logic       poll_write;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            slot_open;
        logic            find_full;
        logic            find_hit;
        logic            raise;
        logic            rate_bad;
        logic            scan_done;
        logic            best_any;
        logic            out_free;
    } dp_stat_t;

    function automatic logic [POW_W-1:0] clamp_pow(input logic [POW_W-1:0] p,
                                                   input logic [POW_W-1:0] hi);
        logic [POW_W-1:0] r;
        r = p;
        if (p < 4'd1)
        begin
            r = 4'd1;
        end
        else if (p > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

/* hdl/vptb_ctrl.sv */
// ----------------------------------------------------------------------------
// Virtual periodic timer bank controller
// Sequences each operation through decode, slot scans, memory writes and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module vptb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vptb_pkg::dp_stat_t dp_stat,
    output vptb_pkg::ctl_cmd_t cmd
);

    vptb_pkg::state_t state_reg;
    vptb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vptb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vptb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vptb_pkg::S_DECODE;
                end
            end
            vptb_pkg::S_DECODE:
            begin
                case (dp_stat.op)
                    vptb_pkg::OP_OPEN:
                    begin
                        state_next = vptb_pkg::S_FIND;
                    end
                    vptb_pkg::OP_CLOSE:
                    begin
                        state_next = dp_stat.slot_open ? vptb_pkg::S_MAX_SCAN
                                                       : vptb_pkg::S_DONE;
                    end
                    vptb_pkg::OP_SET_RATE:
                    begin
                        state_next = dp_stat.slot_open ? vptb_pkg::S_CHECK
                                                       : vptb_pkg::S_DONE;
                    end
                    vptb_pkg::OP_TICK:
                    begin
                        state_next = vptb_pkg::S_TICK_SCAN;
                    end
                    vptb_pkg::OP_POLL:
                    begin
                        state_next = dp_stat.slot_open ? vptb_pkg::S_POLL_RD
                                                       : vptb_pkg::S_DONE;
                    end
                    default:
                    begin
                        state_next = vptb_pkg::S_DONE;
                    end
                endcase
            end
            vptb_pkg::S_FIND:
            begin
                if (dp_stat.find_full)
                begin
                    state_next = vptb_pkg::S_DONE;
                end
                else if (dp_stat.find_hit)
                begin
                    state_next = vptb_pkg::S_OPEN_WR;
                end
            end
            vptb_pkg::S_OPEN_WR:
            begin
                state_next = dp_stat.raise ? vptb_pkg::S_RECOMP : vptb_pkg::S_DONE;
            end
            vptb_pkg::S_CHECK:
            begin
                if (!dp_stat.rate_bad && dp_stat.raise)
                begin
                    state_next = vptb_pkg::S_RECOMP;
                end
                else
                begin
                    state_next = vptb_pkg::S_DONE;
                end
            end
            vptb_pkg::S_MAX_SCAN:
            begin
                if (dp_stat.scan_done)
                begin
                    state_next = vptb_pkg::S_TAKE;
                end
            end
            vptb_pkg::S_TAKE:
            begin
                state_next = dp_stat.best_any ? vptb_pkg::S_RECOMP : vptb_pkg::S_DONE;
            end
            vptb_pkg::S_RECOMP,
            vptb_pkg::S_TICK_SCAN:
            begin
                if (dp_stat.scan_done)
                begin
                    state_next = vptb_pkg::S_DONE;
                end
            end
            vptb_pkg::S_POLL_RD:
            begin
                state_next = vptb_pkg::S_POLL_WR;
            end
            vptb_pkg::S_POLL_WR:
            begin
                state_next = vptb_pkg::S_DONE;
            end
            vptb_pkg::S_DONE:
            begin
                if (dp_stat.out_free)
                begin
                    state_next = vptb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vptb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.status_code = vptb_pkg::STAT_OK;
        cmd.scan_kind   = vptb_pkg::SCAN_TICK;
        in_ready        = 1'b0;
        case (state_reg)
            vptb_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            vptb_pkg::S_DECODE:
            begin
                case (dp_stat.op)
                    vptb_pkg::OP_OPEN,
                    vptb_pkg::OP_TICK:
                    begin
                        cmd.scan_clr = 1'b1;
                    end
                    vptb_pkg::OP_CLOSE:
                    begin
                        if (dp_stat.slot_open)
                        begin
                            cmd.close_write = 1'b1;
                            cmd.scan_clr    = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = vptb_pkg::STAT_NOT_OPEN;
                        end
                    end
                    vptb_pkg::OP_SET_RATE,
                    vptb_pkg::OP_POLL:
                    begin
                        if (!dp_stat.slot_open)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = vptb_pkg::STAT_NOT_OPEN;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            vptb_pkg::S_FIND:
            begin
                if (dp_stat.find_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = vptb_pkg::STAT_NO_SLOT;
                end
                else if (!dp_stat.find_hit)
                begin
                    cmd.find_step = 1'b1;
                end
            end
            vptb_pkg::S_OPEN_WR:
            begin
                cmd.apply      = 1'b1;
                cmd.open_write = 1'b1;
                cmd.scan_clr   = 1'b1;
            end
            vptb_pkg::S_CHECK:
            begin
                if (dp_stat.rate_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = vptb_pkg::STAT_BAD_RATE;
                end
                else
                begin
                    cmd.apply    = 1'b1;
                    cmd.scan_clr = 1'b1;
                end
            end
            vptb_pkg::S_MAX_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_kind = vptb_pkg::SCAN_MAX;
            end
            vptb_pkg::S_TAKE:
            begin
                if (dp_stat.best_any)
                begin
                    cmd.take_best = 1'b1;
                    cmd.scan_clr  = 1'b1;
                end
            end
            vptb_pkg::S_RECOMP:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_kind = vptb_pkg::SCAN_RECOMP;
            end
            vptb_pkg::S_TICK_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_kind = vptb_pkg::SCAN_TICK;
            end
            vptb_pkg::S_POLL_WR:
            begin
                cmd.poll_write = 1'b1;
            end
            vptb_pkg::S_DONE:
            begin
                cmd.out_load = dp_stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/vptb_datapath.sv */
// ----------------------------------------------------------------------------
// Virtual periodic timer bank datapath
// Holds the item, the configuration, the open bits, the per-slot memories,
// the shared rate, the slot scan pipeline and the output register.
// ----------------------------------------------------------------------------
module vptb_datapath #(
    parameter int SLOTS       = vptb_pkg::DEF_SLOTS,
    parameter int MAX_SYS_POW = vptb_pkg::DEF_MAX_SYS_POW
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [vptb_pkg::OP_W-1:0]            operation,
    input  logic [vptb_pkg::SLOT_FIELD_W-1:0]    slot,
    input  logic [vptb_pkg::RATE_W-1:0]          rate_value,
    input  logic                                 cfg_wen,
    input  logic [vptb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vptb_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 out_ready,
    input  vptb_pkg::ctl_cmd_t                   cmd,
    output vptb_pkg::dp_stat_t                   dp_stat,
    output logic                                 out_valid,
    output logic [vptb_pkg::STAT_W-1:0]          status,
    output logic [vptb_pkg::SLOT_FIELD_W-1:0]    granted_slot,
    output logic                                 ready_res,
    output logic [vptb_pkg::MASK_W-1:0]          expired_mask,
    output logic [vptb_pkg::POW_W-1:0]           system_rate_pow,
    output logic [vptb_pkg::POW_W-1:0]           hw_rate_code
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int CNT_W  = MAX_SYS_POW + 1;
    localparam int POW_W  = vptb_pkg::POW_W;
    localparam int MASK_W = vptb_pkg::MASK_W;
    localparam int RATE_W = vptb_pkg::RATE_W;
    localparam logic [POW_W-1:0] POW_HI = POW_W'(MAX_SYS_POW);

    logic [vptb_pkg::OP_W-1:0]         op_reg;
    logic [vptb_pkg::SLOT_FIELD_W-1:0] slot_reg;
    logic [RATE_W-1:0]                 rate_reg;

    logic [vptb_pkg::CFG_W-1:0] def_pow_reg, def_pow_next;
    logic [vptb_pkg::CFG_W-1:0] max_pow_reg, max_pow_next;

    logic [SLOTS-1:0]  open_reg, open_next;
    logic [POW_W-1:0]  shared_reg, shared_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [SLOT_W-1:0] proc_idx_reg, proc_idx_next;
    logic [POW_W-1:0]  best_reg, best_next;
    logic              best_any_reg, best_any_next;

    vptb_pkg::stat_t                   status_reg, status_next;
    logic [vptb_pkg::SLOT_FIELD_W-1:0] granted_reg, granted_next;
    logic                              ready_reg, ready_next;
    logic [MASK_W-1:0]                 mask_reg, mask_next;

    logic                              out_valid_reg, out_valid_next;
    vptb_pkg::stat_t                   out_status_reg;
    logic [vptb_pkg::SLOT_FIELD_W-1:0] out_granted_reg;
    logic                              out_ready_res_reg;
    logic [MASK_W-1:0]                 out_mask_reg;
    logic [POW_W-1:0]                  out_pow_reg;
    logic [POW_W-1:0]                  out_code_reg;

    logic [POW_W-1:0] pow_mem   [SLOTS];
    logic [POW_W-1:0] ratio_mem [SLOTS];
    logic [CNT_W-1:0] cnt_mem   [SLOTS];
    logic [POW_W-1:0] rd_pow_reg;
    logic [POW_W-1:0] rd_ratio_reg;
    logic [CNT_W-1:0] rd_cnt_reg;

    logic              pow_we, ratio_we, cnt_we;
    logic [SLOT_W-1:0] pow_waddr, ratio_waddr, cnt_waddr, rd_addr;
    logic [POW_W-1:0]  pow_wdata, ratio_wdata;
    logic [CNT_W-1:0]  cnt_wdata;

    logic [7:0]        slot_wide;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_in_range;
    logic              slot_open;
    logic [SLOT_W-1:0] idx_lo;
    logic              idx_below;
    logic              is_open_op;
    logic [4:0]        p_rate;
    logic [RATE_W-1:0] rate_minus;
    logic              rate_bad;
    logic [POW_W-1:0]  lim;
    logic [POW_W-1:0]  def_clamped;
    logic [POW_W-1:0]  apply_val;
    logic              raise;
    logic [SLOT_W-1:0] tgt;
    logic              proc_en;
    logic              proc_open;
    logic [7:0]        proc_wide;
    logic [7:0]        tgt_wide;
    logic              cnt_neg;
    logic              tick_dec;
    logic              poll_hit;
    logic [CNT_W-1:0]  reload;
    logic [4:0]        code_wide;

    assign slot_wide     = 8'(slot_reg);
    assign slot_idx      = slot_wide[SLOT_W-1:0];
    assign slot_in_range = slot_wide < 8'(SLOTS);
    assign slot_open     = slot_in_range && open_reg[slot_idx];
    assign idx_lo        = idx_reg[SLOT_W-1:0];
    assign idx_below     = idx_reg < IDX_W'(SLOTS);
    assign is_open_op    = (op_reg == vptb_pkg::OP_OPEN);

    always_comb
    begin
        p_rate = '0;
        for (int i = 0; i < RATE_W; i++)
        begin
            if (rate_reg[i])
            begin
                p_rate = p_rate | 5'(i);
            end
        end
    end

    assign rate_minus  = rate_reg - 32'd1;
    assign lim         = vptb_pkg::clamp_pow(max_pow_reg, POW_HI);
    assign def_clamped = vptb_pkg::clamp_pow(def_pow_reg, POW_HI);
    assign rate_bad    = (rate_reg < 32'd2) || ((rate_reg & rate_minus) != '0)
                         || (p_rate > {1'b0, lim});
    assign apply_val   = is_open_op ? def_clamped : p_rate[POW_W-1:0];
    assign raise       = apply_val > shared_reg;
    assign tgt         = is_open_op ? idx_lo : slot_idx;
    assign tgt_wide    = 8'(tgt);

    assign proc_en   = cmd.scan_run && proc_valid_reg;
    assign proc_open = open_reg[proc_idx_reg];
    assign proc_wide = 8'(proc_idx_reg);
    assign cnt_neg   = rd_cnt_reg[CNT_W-1];
    assign tick_dec  = proc_en && (cmd.scan_kind == vptb_pkg::SCAN_TICK) && proc_open
                       && !cnt_neg;
    assign poll_hit  = cmd.poll_write && cnt_neg;
    assign reload    = CNT_W'(1) << rd_ratio_reg;
    assign rd_addr   = cmd.scan_run ? idx_lo : slot_idx;

    always_comb
    begin
        pow_we      = cmd.apply;
        pow_waddr   = tgt;
        pow_wdata   = apply_val;
        ratio_we    = 1'b0;
        ratio_waddr = tgt;
        ratio_wdata = shared_reg - apply_val;
        cnt_we      = 1'b0;
        cnt_waddr   = tgt;
        cnt_wdata   = '0;
        if (cmd.apply && !raise)
        begin
            ratio_we = 1'b1;
        end
        else if (proc_en && (cmd.scan_kind == vptb_pkg::SCAN_RECOMP) && proc_open)
        begin
            ratio_we    = 1'b1;
            ratio_waddr = proc_idx_reg;
            ratio_wdata = shared_reg - rd_pow_reg;
        end
        if (cmd.apply && cmd.open_write)
        begin
            cnt_we = 1'b1;
        end
        else if (tick_dec)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = proc_idx_reg;
            cnt_wdata = rd_cnt_reg - CNT_W'(1);
        end
        else if (poll_hit)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = slot_idx;
            cnt_wdata = reload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pow_we)
        begin
            pow_mem[pow_waddr] <= pow_wdata;
        end
        if (ratio_we)
        begin
            ratio_mem[ratio_waddr] <= ratio_wdata;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        rd_pow_reg   <= pow_mem[rd_addr];
        rd_ratio_reg <= ratio_mem[rd_addr];
        rd_cnt_reg   <= cnt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= operation;
            slot_reg <= slot;
            rate_reg <= rate_value;
        end
    end

    always_comb
    begin
        def_pow_next = def_pow_reg;
        max_pow_next = max_pow_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                vptb_pkg::CFG_DEFAULT_POW:
                begin
                    def_pow_next = cfg_wdata;
                end
                vptb_pkg::CFG_MAX_POW:
                begin
                    max_pow_next = cfg_wdata;
                end
                default:
                begin
                    def_pow_next = def_pow_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        open_next = open_reg;
        if (cmd.close_write)
        begin
            open_next[slot_idx] = 1'b0;
        end
        if (cmd.apply && cmd.open_write)
        begin
            open_next[tgt] = 1'b1;
        end

        shared_next = shared_reg;
        if (cmd.apply && raise)
        begin
            shared_next = apply_val;
        end
        else if (cmd.take_best)
        begin
            shared_next = best_reg;
        end

        idx_next        = idx_reg;
        proc_valid_next = cmd.scan_run && idx_below;
        proc_idx_next   = idx_lo;
        if (cmd.scan_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.find_step || (cmd.scan_run && idx_below))
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        best_next     = best_reg;
        best_any_next = best_any_reg;
        if (cmd.scan_clr)
        begin
            best_next     = '0;
            best_any_next = 1'b0;
        end
        else if (proc_en && (cmd.scan_kind == vptb_pkg::SCAN_MAX) && proc_open)
        begin
            best_any_next = 1'b1;
            if (rd_pow_reg > best_reg)
            begin
                best_next = rd_pow_reg;
            end
        end
    end

    always_comb
    begin
        status_next  = status_reg;
        granted_next = granted_reg;
        ready_next   = ready_reg;
        mask_next    = mask_reg;
        if (cmd.load_item)
        begin
            status_next  = vptb_pkg::STAT_OK;
            granted_next = '0;
            ready_next   = 1'b0;
            mask_next    = '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_next = cmd.status_code;
            end
            if (cmd.apply && cmd.open_write)
            begin
                granted_next = tgt_wide[vptb_pkg::SLOT_FIELD_W-1:0];
            end
            if (poll_hit)
            begin
                ready_next = 1'b1;
            end
            if (tick_dec && (rd_cnt_reg == '0) && (proc_wide < 8'(MASK_W)))
            begin
                mask_next[proc_wide[2:0]] = 1'b1;
            end
        end
    end

    assign code_wide = 5'(vptb_pkg::RATE_CODE_BASE) - {1'b0, shared_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg    <= status_reg;
            out_granted_reg   <= granted_reg;
            out_ready_res_reg <= ready_reg;
            out_mask_reg      <= mask_reg;
            out_pow_reg       <= shared_reg;
            out_code_reg      <= code_wide[POW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_pow_reg    <= vptb_pkg::DEFAULT_POW_RST;
            max_pow_reg    <= vptb_pkg::MAX_POW_RST;
            open_reg       <= '0;
            shared_reg     <= vptb_pkg::SHARED_POW_RST;
            idx_reg        <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            best_reg       <= '0;
            best_any_reg   <= 1'b0;
            status_reg     <= vptb_pkg::STAT_OK;
            granted_reg    <= '0;
            ready_reg      <= 1'b0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            def_pow_reg    <= def_pow_next;
            max_pow_reg    <= max_pow_next;
            open_reg       <= open_next;
            shared_reg     <= shared_next;
            idx_reg        <= idx_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            best_reg       <= best_next;
            best_any_reg   <= best_any_next;
            status_reg     <= status_next;
            granted_reg    <= granted_next;
            ready_reg      <= ready_next;
            mask_reg       <= mask_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        dp_stat           = '0;
        dp_stat.op        = op_reg;
        dp_stat.slot_open = slot_open;
        dp_stat.find_full = (idx_reg == IDX_W'(SLOTS));
        dp_stat.find_hit  = idx_below && !open_reg[idx_lo];
        dp_stat.raise     = raise;
        dp_stat.rate_bad  = rate_bad;
        dp_stat.scan_done = !idx_below;
        dp_stat.best_any  = best_any_reg;
        dp_stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_slot    = out_granted_reg;
    assign ready_res       = out_ready_res_reg;
    assign expired_mask    = out_mask_reg;
    assign system_rate_pow = out_pow_reg;
    assign hw_rate_code    = out_code_reg;

endmodule

/* hdl/virtual_periodic_timer_bank.sv */
// ----------------------------------------------------------------------------
// Virtual periodic timer bank
// Shares one power-of-two periodic tick source among SLOTS client slots.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation (open, close, set rate, tick or
// poll) and produces exactly one result transfer with the status, the granted
// slot, the poll flag, the tick expiry mask and the shared rate.
// The block works on one operation at a time. A tick walks every slot; a
// close runs a maximum pass over the slots, and an open, close or set rate
// that moves the shared rate then runs a ratio pass. The tick, maximum and
// ratio passes walk the slot memories one slot per cycle through a single
// read port. The input is ready again in the cycle in which the result
// becomes valid, so a new operation cannot start until the previous result
// is valid.
// The output register holds a result until it is taken; while the receiver
// stalls with a result pending, the next result waits inside the block.
// Configuration writes take effect at once; the user must make them while idle, as the block does not enforce it.
// Reset closes all slots, sets the shared exponent to one and restores the
// configuration defaults; the slot memories need no clearing pass.
// ----------------------------------------------------------------------------
module virtual_periodic_timer_bank #(
    parameter int SLOTS       = vptb_pkg::DEF_SLOTS,
    parameter int MAX_SYS_POW = vptb_pkg::DEF_MAX_SYS_POW
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [vptb_pkg::OP_W-1:0]            operation,
    input  logic [vptb_pkg::SLOT_FIELD_W-1:0]    slot,
    input  logic [vptb_pkg::RATE_W-1:0]          rate_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [vptb_pkg::STAT_W-1:0]          status,
    output logic [vptb_pkg::SLOT_FIELD_W-1:0]    granted_slot,
    output logic                                 ready_res,
    output logic [vptb_pkg::MASK_W-1:0]          expired_mask,
    output logic [vptb_pkg::POW_W-1:0]           system_rate_pow,
    output logic [vptb_pkg::POW_W-1:0]           hw_rate_code,
    input  logic                                 cfg_wen,
    input  logic [vptb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vptb_pkg::CFG_W-1:0]           cfg_wdata
);

    vptb_pkg::ctl_cmd_t cmd;
    vptb_pkg::dp_stat_t dp_stat;

    vptb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    vptb_datapath #(
        .SLOTS       (SLOTS),
        .MAX_SYS_POW (MAX_SYS_POW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .operation       (operation),
        .slot            (slot),
        .rate_value      (rate_value),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .dp_stat         (dp_stat),
        .out_valid       (out_valid),
        .status          (status),
        .granted_slot    (granted_slot),
        .ready_res       (ready_res),
        .expired_mask    (expired_mask),
        .system_rate_pow (system_rate_pow),
        .hw_rate_code    (hw_rate_code)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again while an operation is in progress");

    a_rate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (system_rate_pow >= 4'd1)
                      && (system_rate_pow <= vptb_pkg::POW_W'(MAX_SYS_POW)))
        else $error("shared rate exponent out of range");

    a_fail_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != vptb_pkg::STAT_OK))
            |-> ((expired_mask == '0) && !ready_res && (granted_slot == '0)))
        else $error("failed operation reports side results");

    a_tick_only_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (expired_mask != '0)) |-> (!ready_res && (granted_slot == '0)))
        else $error("expiry mask reported together with other results");
`endif

endmodule
